[hdl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and codes of the first-fit allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_DEFRAG = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FAIL      = 2'd1,
    ST_BAD_ERASE = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  localparam logic [0:0] REG_TOTAL_SIZE = 1'b0;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned LEN_W    = 8;

endpackage

[hdl/first_fit_allocator_with_compaction_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_allocator_with_compaction_unit
// first-fit allocator over an address-ordered block table
// ----------------------------------------------------------------------------
// Commands arrive on the in_ channel (valid/ready): alloc, erase, defragment.
// Alloc always gives one out_ transaction (status, new_handle); erase gives
// one only for an illegal handle; defragment and the unused code give none.
// The block table sits in one single-port-write, registered-read memory.
// Each command walks the table one entry at a time through a read-modify-
// write sequencer: alloc scans for the first gap and then shifts entries up,
// erase scans for the handle and shifts entries down, defragment rewrites
// start addresses. Each entry is read in S_RD and evaluated in S_EVAL; each
// shift step reads in S_SHRD and then writes in S_SHWR.
// One command is in work at a time; in_ready is high only while idle and
// the result register is empty. A stalled receiver holds the result in the
// output register, and the next command waits for it.
// Reset (synchronous, rst_n low) empties the table, sets the next handle to
// 1 and total_size to 128; table contents need no clearing.
// The configuration port is APB style, total_size at address 0.
// ----------------------------------------------------------------------------
module first_fit_allocator_with_compaction_unit
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned MEM_UNITS  = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_req_length,
  input  logic [15:0] in_erase_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_new_handle,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  // positions need to hold MEM_UNITS plus a length
  localparam int unsigned PW = $clog2(MEM_UNITS + 256 + 1);
  localparam int unsigned DW = HANDLE_W + PW + LEN_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [PW-1:0] MEMU = PW'(MEM_UNITS);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EVAL, S_SHRD, S_SHWR, S_DONE
  } state_t;

  // configuration register
  logic [7:0] total_size_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= 8'd128;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[1:0] == {REG_TOTAL_SIZE, 1'b0}) begin
      total_size_r <= cfg_pwdata[7:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == {REG_TOTAL_SIZE, 1'b0}) ? {24'd0, total_size_r} : 32'd0;

  logic [PW-1:0] size_use;
  assign size_use = (PW'(total_size_r) < MEMU) ? PW'(total_size_r) : MEMU;

  // table memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  ffa_table #(.DEPTH(MAX_BLOCKS), .AW(AW), .DW(DW)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [HANDLE_W-1:0] r_handle;
  logic [PW-1:0]       r_start;
  logic [LEN_W-1:0]    r_len;
  assign {r_handle, r_start, r_len} = rdata;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [LEN_W-1:0]    len_r;
  logic [HANDLE_W-1:0] eh_r;
  logic [CW-1:0]       live_r, idx_r, hi_r;
  logic [HANDLE_W-1:0] next_handle_r;
  logic [PW-1:0]       pos_r;
  logic                ov_r;
  logic [1:0]          st_r;
  logic [HANDLE_W-1:0] nh_r;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_new_handle = nh_r;

  // scan evaluation on the entry just read
  logic          gap_ok;
  logic [PW-1:0] end_pos;
  always_comb begin
    gap_ok  = (r_start >= pos_r) && ((r_start - pos_r) >= PW'(len_r));
    end_pos = r_start + PW'(r_len);
  end
  logic tail_ok;
  assign tail_ok = (size_use >= pos_r) && ((size_use - pos_r) >= PW'(len_r));

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = {r_handle, r_start, r_len};
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_EVAL: begin
        if (cmd_r == CMD_DEFRAG) begin
          we    = 1'b1;
          wdata = {r_handle, pos_r, r_len};
        end
      end
      S_SHRD: begin
        // alloc shifts up: read idx-1; erase shifts down: read idx+1
        raddr = (cmd_r == CMD_ALLOC) ? AW'(idx_r - 1'b1) : AW'(idx_r + 1'b1);
      end
      S_SHWR: begin
        we = 1'b1;
      end
      S_DONE: begin
        if (cmd_r == CMD_ALLOC && st_r == ST_OK) begin
          we    = 1'b1;
          waddr = hi_r[AW-1:0];
          wdata = {next_handle_r, pos_r, len_r};
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      live_r        <= '0;
      next_handle_r <= 16'd1;
      ov_r          <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= cmd_t'(in_cmd);
            len_r <= in_req_length;
            eh_r  <= in_erase_handle;
            idx_r <= '0;
            pos_r <= '0;
            st_r  <= ST_FAIL;
            nh_r  <= '0;
            case (cmd_t'(in_cmd))
              CMD_ALLOC: begin
                if (live_r >= MAXC || next_handle_r == '0) begin
                  ov_r <= 1'b1;
                end else begin
                  state_r <= S_RD;
                end
              end
              CMD_ERASE, CMD_DEFRAG: state_r <= S_RD;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          if (idx_r == live_r) begin
            // end of table
            if (cmd_r == CMD_ALLOC) begin
              if (tail_ok) begin
                st_r <= ST_OK;
                hi_r <= idx_r;
              end
            end else if (cmd_r == CMD_ERASE) begin
              st_r <= ST_BAD_ERASE;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_RD;
          idx_r   <= idx_r + 1'b1;
          case (cmd_r)
            CMD_ALLOC: begin
              if (gap_ok) begin
                st_r    <= ST_OK;
                hi_r    <= idx_r;
                idx_r   <= live_r;
                state_r <= (live_r == idx_r) ? S_DONE : S_SHRD;
              end else begin
                pos_r <= end_pos;
              end
            end
            CMD_ERASE: begin
              if (r_handle == eh_r) begin
                st_r <= ST_OK;
                if (idx_r + 1'b1 == live_r) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SHRD;
                  idx_r   <= idx_r;
                end
              end
            end
            default: pos_r <= pos_r + PW'(r_len);
          endcase
        end
        S_SHRD: state_r <= S_SHWR;
        S_SHWR: begin
          if (cmd_r == CMD_ALLOC) begin
            if (idx_r - 1'b1 == hi_r) state_r <= S_DONE;
            else state_r <= S_SHRD;
            idx_r <= idx_r - 1'b1;
          end else begin
            if (idx_r + 2'd2 == live_r) state_r <= S_DONE;
            else state_r <= S_SHRD;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
          case (cmd_r)
            CMD_ALLOC: begin
              ov_r <= 1'b1;
              if (st_r == ST_OK) begin
                nh_r          <= next_handle_r;
                live_r        <= live_r + 1'b1;
                next_handle_r <= next_handle_r + 1'b1;
              end
            end
            CMD_ERASE: begin
              if (st_r == ST_OK) begin
                live_r <= live_r - 1'b1;
              end else begin
                ov_r <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ffa_table.sv]
// ----------------------------------------------------------------------------
// ffa_table
// block table memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module ffa_table
  import ffa_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit allocator with compaction
// ----------------------------------------------------------------------------
// Commands are driven on the in_ channel with random gaps. A behavioral copy
// of the block table predicts each accepted command and queues the result
// of each one that gives an out_ transaction. Each out_ transaction is
// compared against the oldest prediction. total_size is rewritten over
// the APB port between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int NBLK = 64;
  localparam int NMEM = 128;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_NONE;
  logic [7:0]  in_req_length = '0;
  logic [15:0] in_erase_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_new_handle;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  first_fit_allocator_with_compaction_unit u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] handle;
  } alloc_result_t;

  // predicted allocator state
  logic [15:0] tbl_handle [NBLK];
  logic [7:0]  tbl_start  [NBLK];
  logic [7:0]  tbl_len    [NBLK];
  int          live_n = 0;
  logic [15:0] handle_ctr = 16'd1;
  logic [7:0]  mem_size = 8'd128;

  alloc_result_t pending_results[$];
  int  mismatches = 0;
  bit  ready_stall = 1'b1;

  // predict one accepted command
  function automatic void predict_command(logic [1:0] cmd, logic [7:0] len,
                                          logic [15:0] hnd);
    int sz, prev, i, j;
    bit fits;
    alloc_result_t r;
    sz = (mem_size < NMEM) ? mem_size : NMEM;
    case (cmd)
      CMD_ALLOC: begin
        r.status = ST_FAIL;
        r.handle = '0;
        if (live_n < NBLK && handle_ctr != 0) begin
          prev = 0;
          for (i = 0; i <= live_n; i++) begin
            if (i < live_n) fits = tbl_start[i] >= prev && tbl_start[i] - prev >= len;
            else fits = sz >= prev && sz - prev >= len;
            if (fits) begin
              for (j = live_n; j > i; j--) begin
                tbl_handle[j] = tbl_handle[j-1];
                tbl_start[j]  = tbl_start[j-1];
                tbl_len[j]    = tbl_len[j-1];
              end
              tbl_handle[i] = handle_ctr;
              tbl_start[i]  = prev[7:0];
              tbl_len[i]    = len;
              live_n++;
              r.status = ST_OK;
              r.handle = handle_ctr;
              handle_ctr = handle_ctr + 16'd1;
              break;
            end
            if (i < live_n) prev = tbl_start[i] + tbl_len[i];
          end
        end
        pending_results.push_back(r);
      end
      CMD_ERASE: begin
        fits = 1'b0;
        for (i = 0; i < live_n; i++) begin
          if (tbl_handle[i] == hnd) begin
            for (j = i; j + 1 < live_n; j++) begin
              tbl_handle[j] = tbl_handle[j+1];
              tbl_start[j]  = tbl_start[j+1];
              tbl_len[j]    = tbl_len[j+1];
            end
            live_n--;
            fits = 1'b1;
            break;
          end
        end
        if (!fits) begin
          r.status = ST_BAD_ERASE;
          r.handle = '0;
          pending_results.push_back(r);
        end
      end
      CMD_DEFRAG: begin
        prev = 0;
        for (i = 0; i < live_n; i++) begin
          tbl_start[i] = prev[7:0];
          prev += tbl_len[i];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one command transaction, valid stays high until the next gap
  task automatic send_command(logic [1:0] cmd, logic [7:0] len, logic [15:0] hnd);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_req_length <= len;
    in_erase_handle <= hnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_command(cmd, len, hnd);
  endtask

  // result checker with random receiver stalls
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d handle=%0d", out_status, out_new_handle);
      end else begin
        e = pending_results.pop_front();
        if (e.status != out_status || e.handle != out_new_handle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp status=%0d handle=%0d got status=%0d handle=%0d",
                     e.status, e.handle, out_status, out_new_handle);
        end
      end
    end
    if (!ready_stall) out_ready <= 1'b1;
    else if (out_ready) out_ready <= ($urandom_range(0, 9) < 7);
    else out_ready <= ($urandom_range(0, 29) < 8) || ($urandom_range(0, 99) == 0);
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * NBLK + 20) @(posedge clk);
  endtask

  task automatic write_total_size(logic [7:0] v);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_TOTAL_SIZE, 1'b0};
    cfg_pwdata <= {24'($urandom()), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    mem_size = v;
  endtask

  // extremes, every command, special cases
  task automatic test_directed();
    send_command(CMD_ALLOC, 8'd0, 16'hFFFF);
    send_command(CMD_ALLOC, 8'd255, 16'd0);
    send_command(CMD_ALLOC, 8'd128, 16'd0);
    send_command(CMD_ERASE, 8'hFF, 16'd0);
    send_command(CMD_ERASE, 8'd0, 16'hFFFF);
    send_command(CMD_ERASE, 8'd0, 16'd1);
    send_command(CMD_ALLOC, 8'd10, 16'd0);
    send_command(CMD_ALLOC, 8'd20, 16'd0);
    send_command(CMD_ALLOC, 8'd5, 16'd0);
    send_command(CMD_ERASE, 8'd0, 16'd3);
    send_command(CMD_NONE, 8'hFF, 16'hFFFF);
    send_command(CMD_DEFRAG, 8'hAA, 16'h5555);
    send_command(CMD_ALLOC, 8'd90, 16'd0);
    send_command(CMD_ALLOC, 8'd3, 16'd0);
    send_command(CMD_ALLOC, 8'd0, 16'd0);
  endtask

  // shrink the memory below live blocks, then oversize it
  task automatic test_size_changes();
    write_total_size(8'd1);
    send_command(CMD_ALLOC, 8'd0, 16'd0);
    send_command(CMD_ALLOC, 8'd1, 16'd0);
    send_command(CMD_DEFRAG, 8'd0, 16'd0);
    send_command(CMD_ALLOC, 8'd0, 16'd0);
    write_total_size(8'd255);
    send_command(CMD_ALLOC, 8'd200, 16'd0);
    send_command(CMD_ALLOC, 8'd1, 16'd0);
  endtask

  // fill the table with zero-length blocks, try one more, then erase them all
  task automatic test_table_full();
    write_total_size(8'd128);
    while (live_n < NBLK) send_command(CMD_ALLOC, 8'd0, 16'd0);
    send_command(CMD_ALLOC, 8'd0, 16'd0);
    while (live_n > 0) send_command(CMD_ERASE, 8'd0, tbl_handle[$urandom_range(0, live_n-1)]);
  endtask

  task automatic random_phase(int count, int maxlen);
    int k, pick;
    logic [15:0] h;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) send_command(CMD_ALLOC, 8'($urandom_range(0, maxlen)), 16'($urandom()));
      else if (pick < 85) begin
        if (live_n > 0 && $urandom_range(0, 9) < 8) h = tbl_handle[$urandom_range(0, live_n-1)];
        else h = 16'($urandom());
        send_command(CMD_ERASE, 8'($urandom()), h);
      end else if (pick < 96) send_command(CMD_DEFRAG, 8'($urandom()), 16'($urandom()));
      else send_command(CMD_NONE, 8'($urandom()), 16'($urandom()));
    end
  endtask

  // random traffic over several sizes
  task automatic test_random();
    write_total_size(8'd128);
    random_phase(300, 12);
    write_total_size(8'($urandom_range(1, 127)));
    random_phase(200, 20);
    write_total_size(8'd128);
    ready_stall = 1'b0;
    random_phase(150, 8);
    ready_stall = 1'b1;
    write_total_size(8'd40);
    random_phase(200, 255);
    write_total_size(8'd200);
    random_phase(150, 6);
  endtask

  // erase of handle zero and of retired handles after emptying the table
  task automatic test_handle_checks();
    logic [15:0] h;
    write_total_size(8'd128);
    while (live_n > 0) send_command(CMD_ERASE, 8'd0, tbl_handle[0]);
    send_command(CMD_ALLOC, 8'd4, 16'd0);
    h = tbl_handle[0];
    send_command(CMD_ERASE, 8'd0, h);
    send_command(CMD_ERASE, 8'd0, h);
    send_command(CMD_ALLOC, 8'd0, 16'd0);
    send_command(CMD_ERASE, 8'd0, 16'd0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_changes();
    test_table_full();
    test_random();
    test_handle_checks();
    drain_results();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #300ms;
    $display("status: fail");
    $finish;
  end
endmodule
